/* rtl/gaussian_metaball_pixel_shader_assert.svh */
// Assertion macros shared by the metaball shader RTL.
`ifndef GAUSSIAN_METABALL_PIXEL_SHADER_ASSERT_SVH
`define GAUSSIAN_METABALL_PIXEL_SHADER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GMPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/gmps_pkg.sv */
// Shared types and constants of the metaball shader.
package gmps_pkg;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic REG_BALL_COUNT = 1'b0;
	localparam logic [5:0] BALL_COUNT_RESET = 6'd10;

	// 9 * 2^47 / R^2: quotient overflows 32 bits when R^2 <= 9 * 2^15
	localparam logic [31:0] SAT_LIMIT = 32'd294912;
	localparam logic [31:0] DIV_SEED = 32'd294912;
	localparam int DIV_STEPS = 32;

	// exp argument 8.0 in Q.40 is 2^43
	localparam int EXP_ARG_BITS = 40 + 3;

	localparam logic [7:0] LEVEL_MAX = 8'd255;
	localparam logic [7:0] LIT_LEVEL = 8'd200;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic mode;
		logic [4:0] ball_index;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic [31:0] gain;
	} cmd_t;

endpackage

/* rtl/gmps_in_if.sv */
// Input word channel: ball writes and pixel requests.
interface gmps_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [4:0] ball_index;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic [15:0] ball_radius;

	modport source (output valid, mode, ball_index, coord_x, coord_y, ball_radius,
		input ready);
	modport sink (input valid, mode, ball_index, coord_x, coord_y, ball_radius,
		output ready);
endinterface

/* rtl/gmps_out_if.sv */
// Output word channel: shaded pixel color.
interface gmps_out_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic lit;

	modport source (output valid, red, green, blue, lit, input ready);
	modport sink (input valid, red, green, blue, lit, output ready);
endinterface

/* rtl/gaussian_metaball_pixel_shader.sv */
// Metaball pixel shader top level: register port, front end, queue, back end.
// A ball write needs no division when its gain is zero or saturated (zero or tiny
// radius); otherwise the front end's one-bit-per-cycle divider works out the gain.
// In the back end one shared distance, multiply and exp-table unit reads the ball
// table one entry per cycle and feeds a four-stage pipe into the accumulator; with
// ball_count 0 the pixel skips the table reads. A two-entry command queue lets the
// front end divide for the next write while a pixel is shaded, and the output
// register holds a finished color while the next item is taken. The ball table has
// no clearing pass; entries are valid only once written.
`include "gaussian_metaball_pixel_shader_assert.svh"

module gaussian_metaball_pixel_shader #(
	parameter int MAX_BALLS = 32,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	gmps_in_if.sink pix_in,
	gmps_out_if.source pix_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import gmps_pkg::*;

	logic [5:0] ball_count_q;
	logic cfg_we;
	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BALL_COUNT);
	assign prdata = (paddr[2] == REG_BALL_COUNT) ? {26'b0, ball_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_count_q <= BALL_COUNT_RESET;
		end else if (cfg_we) begin
			ball_count_q <= pwdata[5:0];
		end
	end

	gmps_front #(
		.MAX_BALLS(MAX_BALLS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd(f_cmd)
	);

	gmps_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_cmd(f_cmd),
		.pop_valid(q_valid),
		.pop_ready(q_ready),
		.pop_cmd(q_cmd)
	);

	gmps_back #(
		.MAX_BALLS(MAX_BALLS),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ball_count(ball_count_q),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd(q_cmd),
		.pix_out(pix_out)
	);

	`GMPS_ASSERT_NEXT(a_cfg_write, cfg_we, ball_count_q == $past(pwdata[5:0]), "ball_count write lost")
	`GMPS_ASSERT_NEXT(a_pixel_enters, pix_in.valid && pix_in.ready && pix_in.mode == MODE_PIXEL, f_valid && f_cmd.mode == MODE_PIXEL, "pixel word not handed to queue")
	`GMPS_ASSERT_NOW(a_color_form, pix_out.valid, (pix_out.red == pix_out.green) && (pix_out.blue == (pix_out.lit ? 8'd255 : 8'd0)), "color word inconsistent")
endmodule

/* rtl/gmps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gmps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* rtl/gmps_front.sv */
// Front end: accepts words, works out ball gain with a serial divider.
module gmps_front #(
	parameter int MAX_BALLS = 32
) (
	input logic clk,
	input logic arst_n,
	gmps_in_if.sink pix_in,
	output logic cmd_valid,
	input logic cmd_ready,
	output gmps_pkg::cmd_t cmd
);
	import gmps_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_DIV = 2'b10
	} fstate_t;

	fstate_t state_q;
	cmd_t cmd_q;
	logic cmd_v_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [31:0] quo_q;
	logic [4:0] step_q;

	logic accept;
	logic idx_ok;
	logic [31:0] rsq;
	logic [32:0] trial;
	logic ge;
	logic [31:0] rem_nx;

	assign pix_in.ready = (state_q == F_IDLE) && !cmd_v_q;
	assign accept = pix_in.valid && pix_in.ready;
	assign idx_ok = 32'(pix_in.ball_index) < MAX_BALLS;
	assign rsq = 32'(pix_in.ball_radius) * 32'(pix_in.ball_radius);

	// one restoring quotient bit per cycle
	assign trial = {rem_q, 1'b0};
	assign ge = trial >= {1'b0, dvs_q};
	assign rem_nx = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cmd_v_q <= 1'b0;
			cmd_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			quo_q <= '0;
			step_q <= '0;
		end else begin
			if (cmd_v_q && cmd_ready) begin
				cmd_v_q <= 1'b0;
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						cmd_q.mode <= pix_in.mode;
						cmd_q.ball_index <= pix_in.ball_index;
						cmd_q.coord_x <= pix_in.coord_x;
						cmd_q.coord_y <= pix_in.coord_y;
						// saturate tiny radii, zero radius adds nothing
						cmd_q.gain <= (pix_in.ball_radius != '0 && rsq <= SAT_LIMIT) ?
							32'hFFFF_FFFF : 32'd0;
						if (pix_in.mode == MODE_PIXEL) begin
							cmd_v_q <= 1'b1;
						end else if (idx_ok) begin
							if (pix_in.ball_radius == '0) begin
								cmd_v_q <= 1'b1;
							end else if (rsq <= SAT_LIMIT) begin
								cmd_v_q <= 1'b1;
							end else begin
								rem_q <= DIV_SEED;
								dvs_q <= rsq;
								step_q <= '0;
								state_q <= F_DIV;
							end
						end
					end
				end
				F_DIV: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[30:0], ge};
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1)) begin
						cmd_q.gain <= {quo_q[30:0], ge};
						cmd_v_q <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign cmd_valid = cmd_v_q;
	assign cmd = cmd_q;
endmodule

/* rtl/gmps_queue.sv */
// Short command queue between front and back end.
module gmps_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input gmps_pkg::cmd_t push_cmd,
	output logic pop_valid,
	input logic pop_ready,
	output gmps_pkg::cmd_t pop_cmd
);
	import gmps_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_cmd = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			if (push) begin
				slot_q[wr_q] <= push_cmd;
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule

/* rtl/gmps_back.sv */
// Back end: ball table, per-ball distance and exp unit, accumulator, color output.
module gmps_back #(
	parameter int MAX_BALLS = 32,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic [5:0] ball_count,
	input logic cmd_valid,
	output logic cmd_ready,
	input gmps_pkg::cmd_t cmd,
	gmps_out_if.source pix_out
);
	import gmps_pkg::*;

	localparam int ADDR_W = $clog2(MAX_BALLS);
	localparam int CNT_W = $clog2(MAX_BALLS + 1);
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int SCL_W = EXP_ARG_BITS + IDX_W + 1;
	localparam int SUM_W = 18 + $clog2(MAX_BALLS);
	localparam int LV_W = SUM_W - 8;

	typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

	// exp(-8k/depth) in Q1.16, from a Q1.31 ratio built with Taylor terms up to the tenth power
	function automatic rom_t build_rom();
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] q;
		logic [63:0] e;
		rom_t r;
		t = (64'd1 << 34) / EXP_TABLE_DEPTH;
		term = 64'd1 << 31;
		q = 64'd1 << 31;
		term = (term * t) >> 31;
		q = q - term;
		term = ((term * t) >> 31) / 2;
		q = q + term;
		term = ((term * t) >> 31) / 3;
		q = q - term;
		term = ((term * t) >> 31) / 4;
		q = q + term;
		term = ((term * t) >> 31) / 5;
		q = q - term;
		term = ((term * t) >> 31) / 6;
		q = q + term;
		term = ((term * t) >> 31) / 7;
		q = q - term;
		term = ((term * t) >> 31) / 8;
		q = q + term;
		term = ((term * t) >> 31) / 9;
		q = q - term;
		term = ((term * t) >> 31) / 10;
		q = q + term;
		e = 64'd1 << 31;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			if (k != 0) begin
				e = (e * q + (64'd1 << 30)) >> 31;
			end
			r[k] = 17'((e + (64'd1 << 14)) >> 15);
		end
		return r;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_RUN = 4'b0010,
		B_DRAIN = 4'b0100,
		B_OUT = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] issue_q;
	logic [SUM_W-1:0] acc_q;

	logic v_s1;
	logic v_s2;
	logic [32:0] d2_s2;
	logic [31:0] gain_s2;
	logic v_s3;
	logic [64:0] p_s3;
	logic gzero_s3;
	logic v_s4;
	logic zero_s4;
	logic [IDX_W-1:0] idx_s4;

	logic out_v_q;
	logic [7:0] red_q;
	logic [7:0] blue_q;
	logic lit_q;

	logic pop;
	logic we;
	logic [63:0] rdata;
	logic signed [15:0] bx;
	logic signed [15:0] by;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [15:0] ax;
	logic [15:0] ay;
	logic [SCL_W-1:0] scaled;
	logic [CNT_W-1:0] lim;
	logic [SUM_W+7:0] acc255;
	logic [LV_W-1:0] lv;
	logic [7:0] level;
	logic is_lit;
	logic pipe_busy;
	logic out_free;

	assign cmd_ready = state_q == B_IDLE;
	assign pop = cmd_valid && cmd_ready;
	assign we = pop && (cmd.mode == MODE_WRITE);

	gmps_ram #(
		.WIDTH(64),
		.DEPTH(MAX_BALLS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(ADDR_W'(cmd.ball_index)),
		.wdata({cmd.coord_x, cmd.coord_y, cmd.gain}),
		.raddr(issue_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	assign lim = (32'(ball_count) > MAX_BALLS) ? CNT_W'(MAX_BALLS) : CNT_W'(ball_count);

	assign bx = rdata[63:48];
	assign by = rdata[47:32];
	assign dx = 17'(px_q) - 17'(bx);
	assign dy = 17'(py_q) - 17'(by);
	assign ax = dx[16] ? 16'(-dx) : 16'(dx);
	assign ay = dy[16] ? 16'(-dy) : 16'(dy);
	assign scaled = SCL_W'(p_s3[EXP_ARG_BITS-1:0]) * SCL_W'(EXP_TABLE_DEPTH);

	// level = floor(sum * 255 / 2^16), clamped
	assign acc255 = {acc_q, 8'b0} - {8'b0, acc_q};
	assign lv = acc255[SUM_W+7:16];
	assign level = (lv >= LV_W'(LEVEL_MAX)) ? LEVEL_MAX : lv[7:0];
	assign is_lit = level >= LIT_LEVEL;

	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign out_free = !out_v_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			px_q <= '0;
			py_q <= '0;
			cnt_q <= '0;
			issue_q <= '0;
			acc_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			d2_s2 <= '0;
			gain_s2 <= '0;
			p_s3 <= '0;
			gzero_s3 <= 1'b0;
			zero_s4 <= 1'b0;
			idx_s4 <= '0;
			out_v_q <= 1'b0;
			red_q <= '0;
			blue_q <= '0;
			lit_q <= 1'b0;
		end else begin
			v_s1 <= state_q == B_RUN;
			v_s2 <= v_s1;
			d2_s2 <= 33'(32'(ax) * 32'(ax)) + 33'(32'(ay) * 32'(ay));
			gain_s2 <= rdata[31:0];
			v_s3 <= v_s2;
			p_s3 <= 65'(gain_s2) * 65'(d2_s2);
			gzero_s3 <= gain_s2 == '0;
			v_s4 <= v_s3;
			zero_s4 <= gzero_s3 || (p_s3[64:EXP_ARG_BITS] != '0);
			idx_s4 <= scaled[EXP_ARG_BITS +: IDX_W];
			if (v_s4 && !zero_s4) begin
				acc_q <= acc_q + SUM_W'(EXP_ROM[idx_s4]);
			end
			// in B_OUT the output register is reloaded below instead
			if (out_v_q && pix_out.ready && state_q != B_OUT) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop && cmd.mode == MODE_PIXEL) begin
						px_q <= cmd.coord_x;
						py_q <= cmd.coord_y;
						cnt_q <= lim;
						issue_q <= '0;
						acc_q <= '0;
						state_q <= (lim == '0) ? B_DRAIN : B_RUN;
					end
				end
				B_RUN: begin
					issue_q <= issue_q + CNT_W'(1);
					if (issue_q == cnt_q - CNT_W'(1)) begin
						state_q <= B_DRAIN;
					end
				end
				B_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						red_q <= is_lit ? level : '0;
						blue_q <= is_lit ? LEVEL_MAX : '0;
						lit_q <= is_lit;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign pix_out.valid = out_v_q;
	assign pix_out.red = red_q;
	assign pix_out.green = red_q;
	assign pix_out.blue = blue_q;
	assign pix_out.lit = lit_q;
endmodule
